### sv/sil_pkg.sv
// sil_pkg: table size, field widths, mode and error codes, state type and the
// table entry layout for the sorted interval lookup unit.
// no dependencies
`timescale 1ns / 1ps

package sil_pkg;

  localparam int MAX_RANGES = 64;
  localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);

  localparam int FRAME_W    = 32;
  localparam int MODE_W     = 2;
  localparam int ERR_W      = 2;
  localparam int HIT_W      = 6;
  localparam int COUNT_W    = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } sil_mode_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_ORDER = 2'd1,
    ERR_FULL  = 2'd2,
    ERR_RSVD  = 2'd3
  } sil_err_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } sil_state_t;

  // one table row: first frame, last frame and precomputed duration
  typedef struct packed {
    logic [FRAME_W-1:0] lo;
    logic [FRAME_W-1:0] hi;
    logic [FRAME_W-1:0] dur;
  } sil_entry_t;

endpackage

### sv/sorted_interval_lookup_unit.sv
// sorted_interval_lookup_unit: table of sorted disjoint frame ranges with a
// compacted position lookup walked one row per cycle. depends on sil_pkg.
//
//  channel   ports                                 handshake
//  input     in_mode in_range_start in_range_end   start high and busy low
//            in_frame
//  result    out_error_code out_found out_hit_index out_valid, one cycle,
//            out_position out_span_start            no back pressure
//            out_span_end out_entry_count
//
// clear, append and the unused mode take no walk; their result shows
// the cycle after the transfer, and busy stays low, so one can follow each cycle
// a query walks the table rows (at most the entry count,
// at most 64): the shared compare and add unit handles one table row a cycle
// the result shows in the cycle the query ends; busy is high while walking
// reset (synchronous, rst_n low) empties the table and zeroes the span
`timescale 1ns / 1ps

module sorted_interval_lookup_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [sil_pkg::MODE_W-1:0]   in_mode,
  input  logic [sil_pkg::FRAME_W-1:0]  in_range_start,
  input  logic [sil_pkg::FRAME_W-1:0]  in_range_end,
  input  logic [sil_pkg::FRAME_W-1:0]  in_frame,
  output logic                         out_valid,
  output logic [sil_pkg::ERR_W-1:0]    out_error_code,
  output logic                         out_found,
  output logic [sil_pkg::HIT_W-1:0]    out_hit_index,
  output logic [sil_pkg::FRAME_W-1:0]  out_position,
  output logic [sil_pkg::FRAME_W-1:0]  out_span_start,
  output logic [sil_pkg::FRAME_W-1:0]  out_span_end,
  output logic [sil_pkg::COUNT_W-1:0]  out_entry_count
);

  import sil_pkg::*;

  // range table
  sil_entry_t             mem [MAX_RANGES];
  sil_entry_t             rd_q_r;
  logic [IDX_W-1:0]       rd_addr;
  logic                   wr_en;
  sil_entry_t             wr_data;

  // control and table state
  sil_state_t             state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [FRAME_W-1:0]     span_lo_r, span_lo_nxt;
  logic [FRAME_W-1:0]     span_hi_r, span_hi_nxt;
  logic [FRAME_W-1:0]     last_end_r, last_end_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [FRAME_W-1:0]     sum_r, sum_nxt;
  logic [FRAME_W-1:0]     frame_r, frame_nxt;

  // result registers
  logic                   valid_r, valid_nxt;
  sil_err_t               err_r, err_nxt;
  logic                   found_r, found_nxt;
  logic [IDX_W-1:0]       hit_r, hit_nxt;
  logic [FRAME_W-1:0]     pos_r, pos_nxt;

  // walk datapath
  logic [FRAME_W:0]       diff;
  logic                   below;
  logic                   inside_rng;
  logic [FRAME_W-1:0]     addend;
  logic [FRAME_W-1:0]     sum_add;
  logic                   last_row;
  logic                   accept;
  logic                   full;

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r != ST_IDLE);
  assign full       = (count_r >= CNT_W'(MAX_RANGES));

  assign diff       = {1'b0, frame_r} - {1'b0, rd_q_r.lo};
  assign below      = diff[FRAME_W];
  assign inside_rng = (frame_r <= rd_q_r.hi);
  assign addend     = inside_rng ? diff[FRAME_W-1:0] : rd_q_r.dur;
  assign sum_add    = sum_r + addend;
  assign last_row   = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  assign rd_addr    = (state_r == ST_WALK) ? (idx_r + IDX_W'(1)) : '0;

  assign wr_data    = {in_range_start, in_range_end,
                       in_range_end - in_range_start + FRAME_W'(1)};

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    span_lo_nxt  = span_lo_r;
    span_hi_nxt  = span_hi_r;
    last_end_nxt = last_end_r;
    idx_nxt      = idx_r;
    sum_nxt      = sum_r;
    frame_nxt    = frame_r;
    valid_nxt    = 1'b0;
    err_nxt      = err_r;
    found_nxt    = found_r;
    hit_nxt      = hit_r;
    pos_nxt      = pos_r;
    wr_en        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          err_nxt   = ERR_OK;
          found_nxt = 1'b0;
          hit_nxt   = '0;
          pos_nxt   = '0;
          case (in_mode)
            MODE_CLEAR: begin
              valid_nxt   = 1'b1;
              count_nxt   = '0;
              span_lo_nxt = '0;
              span_hi_nxt = '0;
            end
            MODE_APPEND: begin
              valid_nxt = 1'b1;
              if (full) begin
                err_nxt = ERR_FULL;
              end else if (in_range_start > in_range_end) begin
                err_nxt = ERR_ORDER;
              end else if ((count_r != '0) && !(last_end_r < in_range_start)) begin
                err_nxt = ERR_ORDER;
              end else begin
                wr_en        = 1'b1;
                count_nxt    = count_r + CNT_W'(1);
                last_end_nxt = in_range_end;
                if (count_r == '0) begin
                  span_lo_nxt = in_range_start;
                  span_hi_nxt = in_range_end;
                end else begin
                  if (in_range_start < span_lo_r) span_lo_nxt = in_range_start;
                  if (in_range_end > span_hi_r)   span_hi_nxt = in_range_end;
                end
              end
            end
            MODE_QUERY: begin
              if (count_r == '0) begin
                valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_WALK;
                idx_nxt   = '0;
                sum_nxt   = '0;
                frame_nxt = in_frame;
              end
            end
            default: begin
              valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (below) begin
          valid_nxt = 1'b1;
          pos_nxt   = sum_r;
          state_nxt = ST_IDLE;
        end else if (inside_rng) begin
          valid_nxt = 1'b1;
          found_nxt = 1'b1;
          hit_nxt   = idx_r;
          pos_nxt   = sum_add;
          state_nxt = ST_IDLE;
        end else if (last_row) begin
          valid_nxt = 1'b1;
          pos_nxt   = sum_add;
          state_nxt = ST_IDLE;
        end else begin
          sum_nxt = sum_add;
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // table write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      span_lo_r <= '0;
      span_hi_r <= '0;
      valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      span_lo_r <= span_lo_nxt;
      span_hi_r <= span_hi_nxt;
      valid_r   <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_end_r <= last_end_nxt;
    idx_r      <= idx_nxt;
    sum_r      <= sum_nxt;
    frame_r    <= frame_nxt;
    err_r      <= err_nxt;
    found_r    <= found_nxt;
    hit_r      <= hit_nxt;
    pos_r      <= pos_nxt;
  end

  assign out_valid       = valid_r;
  assign out_error_code  = err_r;
  assign out_found       = found_r;
  assign out_hit_index   = HIT_W'(hit_r);
  assign out_position    = pos_r;
  assign out_span_start  = span_lo_r;
  assign out_span_end    = span_hi_r;
  assign out_entry_count = COUNT_W'(count_r);

  // a result never shows while a query is still walking
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // operations other than a query answer in the next cycle
  a_short_op: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_mode != MODE_QUERY)) |=> out_valid)
    else $error("missing result after short operation");

  // table never overfills
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RANGES))
    else $error("entry count above table size");

  // the walk stays below the entry count
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> ((CNT_W'(idx_r) + CNT_W'(1)) <= count_r))
    else $error("walk index past last entry");

  // a hit is only reported on a query with no error
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_error_code == ERR_OK))
    else $error("hit reported with error code");

endmodule
